// ===== sv/pdu_pkg.sv =====
// Package for the PID drive update block: widths, register indexes and the
// configuration bundle shared by the datapath, the top level and the checker.
// Depends on nothing.
package pdu_pkg;

  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned ErrW    = FieldW + 1;
  localparam int unsigned AccW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = LimitW;
  localparam int unsigned InDataW = 2 * FieldW;
  localparam int unsigned OutDataW = AccW;

  localparam logic [LimitW-1:0] LimitReset = 31'd5000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_PROP  = 2'd0,
    REG_GAIN_INTEG = 2'd1,
    REG_GAIN_DERIV = 2'd2,
    REG_OUT_LIMIT  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [GainW-1:0] gain_prop;
    logic signed [GainW-1:0] gain_integ;
    logic signed [GainW-1:0] gain_deriv;
    logic [LimitW-1:0]       out_limit;
  } cfg_t;

endpackage

// ===== sv/pid_drive_update.sv =====
// PID drive update top level: stream ports, configuration registers, state
// and the result register. Depends on pdu_pkg and pdu_core.
// An accepted request passes one input register and one result register on its
// way to the output. Throughput is one request per cycle while the output
// does not stall, set by the single pass through pdu_core.
// A synchronous reset clears the gains, the error history, the integral sum
// and the drive accumulator, and sets the output limit to 5000.
module pid_drive_update (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pdu_pkg::InDataW-1:0]   s_tdata,   // sample[15:0], target[31:16]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pdu_pkg::OutDataW-1:0]  m_tdata,   // drive[31:0]
  output logic                          m_tuser,   // clipped[0]
  input  logic                          cfg_we,
  input  logic [pdu_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pdu_pkg::CfgW-1:0]      cfg_data
);

  pdu_pkg::cfg_t cfg;

  logic                                 in_valid;
  logic signed [pdu_pkg::ErrW-1:0]      in_err;
  logic signed [pdu_pkg::ErrW-1:0]      last_error;
  logic signed [pdu_pkg::AccW-1:0]      error_sum;
  logic signed [pdu_pkg::AccW-1:0]      drive_acc;
  logic signed [pdu_pkg::AccW-1:0]      error_sum_next;
  logic signed [pdu_pkg::AccW-1:0]      drive_next;
  logic                                 clip_next;
  logic signed [pdu_pkg::FieldW-1:0]    sample;
  logic signed [pdu_pkg::FieldW-1:0]    target;
  logic                                 out_free;
  logic                                 advance;
  logic                                 take;

  assign sample   = s_tdata[15:0];
  assign target   = s_tdata[31:16];
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop  <= '0;
      cfg.gain_integ <= '0;
      cfg.gain_deriv <= '0;
      cfg.out_limit  <= pdu_pkg::LimitReset;
    end else if (cfg_we) begin
      case (pdu_pkg::reg_index_t'(cfg_index))
        pdu_pkg::REG_GAIN_PROP:  cfg.gain_prop  <= cfg_data[15:0];
        pdu_pkg::REG_GAIN_INTEG: cfg.gain_integ <= cfg_data[15:0];
        pdu_pkg::REG_GAIN_DERIV: cfg.gain_deriv <= cfg_data[15:0];
        pdu_pkg::REG_OUT_LIMIT:  cfg.out_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_err <= {target[15], target} - {sample[15], sample};
    end
  end

  pdu_core u_core (
    .cfg            (cfg),
    .err            (in_err),
    .last_error     (last_error),
    .error_sum      (error_sum),
    .drive_acc      (drive_acc),
    .error_sum_next (error_sum_next),
    .drive_next     (drive_next),
    .clipped        (clip_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
      drive_acc  <= '0;
    end else if (advance) begin
      last_error <= in_err;
      error_sum  <= error_sum_next;
      drive_acc  <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= drive_next;
      m_tuser <= clip_next;
    end
  end

endmodule

// ===== sv/pdu_core.sv =====
// Single-pass PID datapath: saturating integral, three Q8.8 products and the
// clamped drive accumulator update. Uses types and widths from pdu_pkg.
module pdu_core (
  input  pdu_pkg::cfg_t                        cfg,
  input  logic signed [pdu_pkg::ErrW-1:0]      err,
  input  logic signed [pdu_pkg::ErrW-1:0]      last_error,
  input  logic signed [pdu_pkg::AccW-1:0]      error_sum,
  input  logic signed [pdu_pkg::AccW-1:0]      drive_acc,
  output logic signed [pdu_pkg::AccW-1:0]      error_sum_next,
  output logic signed [pdu_pkg::AccW-1:0]      drive_next,
  output logic                                 clipped
);

  logic signed [32:0] sum_wide;
  logic signed [17:0] err_diff;
  logic [32:0]        p_prod;
  logic [47:0]        i_prod;
  logic [33:0]        d_prod;
  logic signed [24:0] p_term;
  logic signed [39:0] i_term;
  logic signed [25:0] d_term;
  logic signed [41:0] total;
  logic signed [41:0] lim_pos;
  logic signed [41:0] lim_neg;

  assign sum_wide = {error_sum[31], error_sum} + {{16{err[16]}}, err};

  always_comb begin
    if (sum_wide[32] != sum_wide[31]) begin
      error_sum_next = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      error_sum_next = sum_wide[31:0];
    end
  end

  assign err_diff = {last_error[16], last_error} - {err[16], err};

  // Low bits of the product of sign-extended operands equal the signed product.
  assign p_prod = {{17{cfg.gain_prop[15]}}, cfg.gain_prop} * {{16{err[16]}}, err};
  assign i_prod = {{32{cfg.gain_integ[15]}}, cfg.gain_integ}
                * {{16{error_sum_next[31]}}, error_sum_next};
  assign d_prod = {{18{cfg.gain_deriv[15]}}, cfg.gain_deriv}
                * {{16{err_diff[17]}}, err_diff};

  // Dropping the low eight bits of a two's complement value rounds down.
  assign p_term = p_prod[32:8];
  assign i_term = i_prod[47:8];
  assign d_term = d_prod[33:8];

  assign total = {{10{drive_acc[31]}}, drive_acc}
               + {{17{p_term[24]}}, p_term}
               + {{2{i_term[39]}}, i_term}
               + {{16{d_term[25]}}, d_term};

  assign lim_pos = {11'b0, cfg.out_limit};
  assign lim_neg = -lim_pos;

  always_comb begin
    if (total > lim_pos) begin
      drive_next = lim_pos[31:0];
      clipped    = 1'b1;
    end else if (total < lim_neg) begin
      drive_next = lim_neg[31:0];
      clipped    = 1'b1;
    end else begin
      drive_next = total[31:0];
      clipped    = 1'b0;
    end
  end

endmodule

// ===== sv/pdu_check.sv =====
// Port-level checker for pid_drive_update, attached by the bind below.
// Depends on pdu_pkg for port widths.
module pdu_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pdu_pkg::OutDataW-1:0]  m_tdata,
  input logic                          m_tuser
);

  // A result held back by the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Requests are refused only when a result is stalled on the output.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("request refused without a stalled result");

  // An accepted request reaches the output, past the input and result registers, when the consumer is ready for it.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("result missing two cycles after request");

endmodule

bind pid_drive_update pdu_check u_pdu_check (.*);

// ===== bench/pdu_checker.sv =====
`timescale 1ns / 100ps
// Checker for the PID drive update block: watches the request, result and
// register write ports, predicts each drive result and compares it.
// Depends on pdu_pkg.
module pdu_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [pdu_pkg::InDataW-1:0]   s_tdata,   // sample[15:0], target[31:16]
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [pdu_pkg::OutDataW-1:0]  m_tdata,   // drive[31:0]
  input  logic                          m_tuser,   // clipped[0]
  input  logic                          cfg_we,
  input  logic [pdu_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pdu_pkg::CfgW-1:0]      cfg_data,
  output int                            pending,
  output int                            mismatches
);

  typedef struct {
    logic signed [pdu_pkg::AccW-1:0] drive;
    logic                            clipped;
  } drive_result_t;

  pdu_pkg::cfg_t                     cfg;
  logic signed [pdu_pkg::ErrW-1:0]   prev_err;
  logic signed [pdu_pkg::AccW-1:0]   err_total;
  logic signed [pdu_pkg::AccW-1:0]   drive_acc;
  drive_result_t                     expected_drive[$];

  task automatic update_drive(input logic [pdu_pkg::InDataW-1:0] req,
                              output drive_result_t res);
    longint err, sum, p, i, d, nxt, lim;
    err = longint'($signed(req[2*pdu_pkg::FieldW-1:pdu_pkg::FieldW]))
        - longint'($signed(req[pdu_pkg::FieldW-1:0]));
    sum = err_total + err;
    if (sum > longint'(32'sh7FFF_FFFF)) sum = 32'sh7FFF_FFFF;
    if (sum < -longint'(64'sd2147483648)) sum = -longint'(64'sd2147483648);
    err_total = sum[pdu_pkg::AccW-1:0];
    p = (longint'(cfg.gain_prop) * err) >>> 8;
    i = (longint'(cfg.gain_integ) * longint'(err_total)) >>> 8;
    d = (longint'(cfg.gain_deriv) * (longint'(prev_err) - err)) >>> 8;
    prev_err = err[pdu_pkg::ErrW-1:0];
    lim = longint'(cfg.out_limit);
    nxt = longint'(drive_acc) + p + i + d;
    res.clipped = 1'b0;
    if (nxt > lim) begin
      nxt = lim;
      res.clipped = 1'b1;
    end
    if (nxt < -lim) begin
      nxt = -lim;
      res.clipped = 1'b1;
    end
    drive_acc = nxt[pdu_pkg::AccW-1:0];
    res.drive = drive_acc;
  endtask

  always @(posedge clk) begin
    drive_result_t res;
    if (rst) begin
      cfg.gain_prop = '0;
      cfg.gain_integ = '0;
      cfg.gain_deriv = '0;
      cfg.out_limit = pdu_pkg::LimitReset;
      prev_err = '0;
      err_total = '0;
      drive_acc = '0;
      mismatches = 0;
      expected_drive.delete();
    end else begin
      if (cfg_we) begin
        case (pdu_pkg::reg_index_t'(cfg_index))
          pdu_pkg::REG_GAIN_PROP:  cfg.gain_prop = cfg_data[pdu_pkg::GainW-1:0];
          pdu_pkg::REG_GAIN_INTEG: cfg.gain_integ = cfg_data[pdu_pkg::GainW-1:0];
          pdu_pkg::REG_GAIN_DERIV: cfg.gain_deriv = cfg_data[pdu_pkg::GainW-1:0];
          pdu_pkg::REG_OUT_LIMIT:  cfg.out_limit = cfg_data[pdu_pkg::LimitW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        update_drive(s_tdata, res);
        expected_drive.push_back(res);
      end
      if (m_tvalid && m_tready) begin
        if (expected_drive.size() == 0) begin
          $error("drive result %0d arrived with no request outstanding", $signed(m_tdata));
          mismatches++;
        end else begin
          res = expected_drive.pop_front();
          if ($signed(m_tdata) !== res.drive) begin
            $error("drive: expected %0d, got %0d", res.drive, $signed(m_tdata));
            mismatches++;
          end
          if (m_tuser !== res.clipped) begin
            $error("clipped: expected %0b, got %0b", res.clipped, m_tuser);
            mismatches++;
          end
        end
      end
    end
    pending <= expected_drive.size();
  end

endmodule

// ===== bench/pid_drive_update_tb.sv =====
`timescale 1ns / 100ps
// Top of the PID drive update testbench: clock, reset, requests, register
// writes and the verdict. Depends on pdu_pkg, pid_drive_update and pdu_checker.
module pid_drive_update_tb;

  localparam int StallLimit = 1000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [pdu_pkg::InDataW-1:0]    s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [pdu_pkg::OutDataW-1:0]   m_tdata;
  logic                           m_tuser;
  logic                           cfg_we;
  logic [pdu_pkg::CfgIdxW-1:0]    cfg_index;
  logic [pdu_pkg::CfgW-1:0]       cfg_data;
  int                             pending;
  int                             mismatches;
  int                             stall_cycles = 0;
  bit                             tx_idle_on = 1'b1;
  bit                             rx_idle_on = 1'b1;
  logic [pdu_pkg::FieldW-1:0]     corner_vals[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

  pid_drive_update i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pdu_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .mismatches(mismatches)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: a random hold-off before each result when rx_idle_on is set, then ready until one is taken.
  initial begin
    int unsigned gap;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_request(input logic [pdu_pkg::FieldW-1:0] smp,
                              input logic [pdu_pkg::FieldW-1:0] tgt);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {tgt, smp};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic await_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input pdu_pkg::reg_index_t idx,
                           input logic [pdu_pkg::CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [pdu_pkg::CfgW-1:0] gain_word();
    logic [pdu_pkg::GainW-1:0]                g;
    logic [pdu_pkg::CfgW-pdu_pkg::GainW-1:0]  junk;
    case ($urandom_range(0, 9))
      0: g = 16'h7FFF;
      1: g = 16'h8000;
      2: g = 16'h0000;
      3: g = 16'($urandom);
      default: g = 16'($urandom_range(0, 1024)) - 16'd512;
    endcase
    junk = $urandom_range(0, 1) ? (pdu_pkg::CfgW - pdu_pkg::GainW)'($urandom) : '0;
    return {junk, g};
  endfunction

  task automatic random_phase(input int unsigned count);
    logic [pdu_pkg::LimitW-1:0] lim;
    logic [pdu_pkg::FieldW-1:0] smp, tgt;
    case ($urandom_range(0, 5))
      0: lim = '0;
      1: lim = '1;
      2: lim = 31'($urandom);
      3: lim = 31'($urandom_range(1, 100));
      default: lim = 31'($urandom_range(1000, 1000000));
    endcase
    write_reg(pdu_pkg::REG_GAIN_PROP, gain_word());
    write_reg(pdu_pkg::REG_GAIN_INTEG, gain_word());
    write_reg(pdu_pkg::REG_GAIN_DERIV, gain_word());
    write_reg(pdu_pkg::REG_OUT_LIMIT, lim);
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: begin
          tgt = 16'($urandom);
          smp = 16'($urandom);
        end
        1: begin
          tgt = corner_vals[$urandom_range(0, 3)];
          smp = corner_vals[$urandom_range(0, 3)];
        end
        default: begin
          tgt = 16'($urandom);
          smp = tgt + 16'($urandom_range(0, 64)) - 16'd32;
        end
      endcase
      send_request(smp, tgt);
    end
    await_idle();
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = pdu_pkg::REG_GAIN_PROP;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset gains are zero, so the drive must stay at zero.
    send_request(16'h8000, 16'h7FFF);
    send_request(16'h7FFF, 16'h8000);
    send_request(16'h0000, 16'h0000);
    await_idle();

    // Extreme gains and the widest limit against the field extremes.
    write_reg(pdu_pkg::REG_GAIN_PROP, 31'h0000_7FFF);
    write_reg(pdu_pkg::REG_GAIN_INTEG, 31'h0000_8000);
    write_reg(pdu_pkg::REG_GAIN_DERIV, 31'h0000_8000);
    write_reg(pdu_pkg::REG_OUT_LIMIT, 31'h7FFF_FFFF);
    send_request(16'h8000, 16'h7FFF);
    send_request(16'h7FFF, 16'h8000);
    send_request(16'h0000, 16'hFFFF);
    send_request(16'hFFFF, 16'h0000);
    send_request(16'h0000, 16'h0000);
    send_request(16'h7FFF, 16'h7FFF);
    await_idle();

    // A zero limit pins the drive at zero.
    write_reg(pdu_pkg::REG_OUT_LIMIT, 31'd0);
    send_request(16'd5, 16'd9);
    send_request(16'd0, 16'd0);
    await_idle();

    // Unit proportional gain: landing exactly on the bound is not clipped.
    write_reg(pdu_pkg::REG_GAIN_PROP, 31'd256);
    write_reg(pdu_pkg::REG_GAIN_INTEG, 31'd0);
    write_reg(pdu_pkg::REG_GAIN_DERIV, 31'd0);
    write_reg(pdu_pkg::REG_OUT_LIMIT, 31'd1000);
    send_request(16'd0, 16'd1000);
    send_request(16'd7, 16'd7);
    send_request(16'd2000, 16'd0);
    send_request(16'd0, 16'hFFFF);
    await_idle();

    // Lowering the limit below the held drive clamps it on the next request.
    write_reg(pdu_pkg::REG_OUT_LIMIT, 31'h7FFF_FFFF);
    send_request(16'd0, 16'd30000);
    await_idle();
    write_reg(pdu_pkg::REG_OUT_LIMIT, 31'd500);
    send_request(16'd0, 16'd0);
    await_idle();

    repeat (7) random_phase(100);

    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pdu_pkg.sv
sv/pdu_core.sv
sv/pid_drive_update.sv
sv/pdu_check.sv
bench/pdu_checker.sv
bench/pid_drive_update_tb.sv
